// ===== design/cpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants of the competitive population Euler step block:
// field widths, datapath widths, register indexes, sequencer phases and state.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

  // Fixed widths of the item fields and registers.
  localparam int unsigned MAXSP       = 5;
  localparam int unsigned SPECIES_DEF = 5;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned STEP_W      = 8;
  localparam int unsigned COEF_W      = 12;
  localparam int unsigned ROW_W       = COEF_W * MAXSP;
  localparam int unsigned DT_W        = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = ROW_W;
  localparam int unsigned IDX_W       = $clog2(MAXSP);

  // Datapath widths.
  // ACC_W: sum of five 12x16 products. T_W: rate times count.
  // Q_W: rate times count times dt. M_W: magnitude of (1 - sum).
  // D_W: full product of Q_W and M_W bits.
  localparam int unsigned ACC_W = 31;
  localparam int unsigned T_W   = COEF_W + CNT_W;
  localparam int unsigned Q_W   = T_W + DT_W;
  localparam int unsigned M_W   = ACC_W;
  localparam int unsigned D_W   = Q_W + M_W;
  localparam int unsigned FRAC  = 36;

  // One in the unit of the competition coefficients (2^-16).
  localparam logic [ACC_W-1:0] ONE_ALPHA = ACC_W'(65536);
  localparam logic [DT_W-1:0]  DT_RESET  = DT_W'(256);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DT      = 3'd6;

  // Operation that the lanes carry out in the current cycle.
  typedef enum logic [2:0] {
    PH_NONE,
    PH_MAC,
    PH_RATE,
    PH_DT,
    PH_LO,
    PH_HI,
    PH_ADD,
    PH_FIN
  } phase_kind_t;

  // Sequencer state.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } cpe_state_t;

  // Control bundle from the sequencer to the lanes and the merge logic.
  typedef struct packed {
    phase_kind_t      kind;
    logic [IDX_W-1:0] mac_idx;
    logic             mac_first;
    logic             load;
    logic             fin;
    logic             out_load;
  } cpe_ctl_t;

endpackage

`default_nettype wire

// ===== design/cpe_if.sv =====
// ----------------------------------------------------------------------------
// cpe_if
// Valid/ready channels of the block: the input channel with five counts and
// a step count, and the result channel with five counts and a flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpe_in_if;
  import cpe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  count_a;
  logic [CNT_W-1:0]  count_b;
  logic [CNT_W-1:0]  count_c;
  logic [CNT_W-1:0]  count_d;
  logic [CNT_W-1:0]  count_e;
  logic [STEP_W-1:0] step_count;

  modport source (
    output valid, count_a, count_b, count_c, count_d, count_e, step_count,
    input  ready
  );
  modport sink (
    input  valid, count_a, count_b, count_c, count_d, count_e, step_count,
    output ready
  );
endinterface

interface cpe_out_if;
  import cpe_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] next_a;
  logic [CNT_W-1:0] next_b;
  logic [CNT_W-1:0] next_c;
  logic [CNT_W-1:0] next_d;
  logic [CNT_W-1:0] next_e;
  logic             saturated;

  modport source (
    output valid, next_a, next_b, next_c, next_d, next_e, saturated,
    input  ready
  );
  modport sink (
    input  valid, next_a, next_b, next_c, next_d, next_e, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/competitive_population_euler_step_top.sv =====
// ----------------------------------------------------------------------------
// competitive_population_euler_step_top
// Applies a number of forward Euler steps of competitive Lotka-Volterra to
// five species counts, one lane per species, in fixed point.
// ----------------------------------------------------------------------------
// Usage:
// The input channel in_ch carries five counts and a step count; each transfer
// starts one item. The result channel out_ch returns one transfer per item:
// the five new counts and a flag that is set when any count saturated.
// Coefficients, growth rates and dt are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while no item is in flight, since
// the block has no check for this. An index beyond the list is ignored.
// Each Euler step runs as a series of phases, set by the one multiplier of
// every lane: SPECIES products for the interaction sum, then the rate, dt and
// two partial products, an add and the final rounding.
// A new item is taken only after the last result is in the output register.
// The output register holds a finished result until the receiver takes it;
// the next item runs meanwhile and waits at its end if the register is full.
// Synchronous reset clears the sequencer, the output valid, all coefficients
// and growth rates, and sets dt to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module competitive_population_euler_step_top #(
  parameter int unsigned SPECIES = cpe_pkg::SPECIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cpe_in_if.sink                         in_ch,
  cpe_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cpe_pkg::*;

  logic [ROW_W-1:0]  alpha_r [MAXSP];
  logic [ROW_W-1:0]  growth_r;
  logic [DT_W-1:0]   dt_r;

  logic [CNT_W-1:0]  count_r [MAXSP];
  logic              sat_r;
  logic [CNT_W-1:0]  out_cnt_r [MAXSP];
  logic              out_sat_r;
  logic              out_valid_r;

  logic [CNT_W-1:0]  lane_next [MAXSP];
  logic [MAXSP-1:0]  lane_sat;
  logic [CNT_W-1:0]  in_cnt [MAXSP];
  logic              out_free;
  cpe_ctl_t          ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAXSP; k++) begin
        alpha_r[k] <= '0;
      end
      growth_r <= '0;
      dt_r     <= DT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [REG_ALPHA_0:REG_ALPHA_4]: alpha_r[cfg_index] <= cfg_wdata[ROW_W-1:0];
        REG_GROWTH:                growth_r <= cfg_wdata[ROW_W-1:0];
        REG_DT:                    dt_r <= cfg_wdata[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  assign out_free = !out_valid_r || out_ch.ready;

  cpe_ctrl #(
    .SPECIES (SPECIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .step_count (in_ch.step_count),
    .out_free   (out_free),
    .in_ready   (in_ch.ready),
    .ctl        (ctl)
  );

  // One lane per active species; the others keep their counts.
  for (genvar g = 0; g < MAXSP; g++) begin : g_lane
    if (g < SPECIES) begin : g_on
      cpe_lane #(
        .LANE (g)
      ) u_lane (
        .clk       (clk),
        .ctl       (ctl),
        .counts    (count_r),
        .alpha_row (alpha_r[g]),
        .rate      (growth_r[g*COEF_W +: COEF_W]),
        .dt        (dt_r),
        .next_cnt  (lane_next[g]),
        .sat_flag  (lane_sat[g])
      );
    end else begin : g_off
      assign lane_next[g] = count_r[g];
      assign lane_sat[g]  = 1'b0;
    end
  end

  assign in_cnt[0] = in_ch.count_a;
  assign in_cnt[1] = in_ch.count_b;
  assign in_cnt[2] = in_ch.count_c;
  assign in_cnt[3] = in_ch.count_d;
  assign in_cnt[4] = in_ch.count_e;

  // Merge: all lanes update the counts together at the end of a step.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int k = 0; k < MAXSP; k++) begin
        count_r[k] <= in_cnt[k];
      end
      sat_r <= 1'b0;
    end else if (ctl.fin) begin
      for (int k = 0; k < MAXSP; k++) begin
        count_r[k] <= lane_next[k];
      end
      sat_r <= sat_r | (|lane_sat);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      for (int k = 0; k < MAXSP; k++) begin
        out_cnt_r[k] <= count_r[k];
      end
      out_sat_r <= sat_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_a    = out_cnt_r[0];
  assign out_ch.next_b    = out_cnt_r[1];
  assign out_ch.next_c    = out_cnt_r[2];
  assign out_ch.next_d    = out_cnt_r[3];
  assign out_ch.next_e    = out_cnt_r[4];
  assign out_ch.saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== design/cpe_lane.sv =====
// ----------------------------------------------------------------------------
// cpe_lane
// Datapath of one species. A single multiplier is shared over the phases of
// an Euler step: interaction sum, rate product, dt product, the two halves of
// the final product, then rounding, clamping and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic                          clk,
  input  cpe_pkg::cpe_ctl_t             ctl,
  input  logic [cpe_pkg::CNT_W-1:0]     counts [cpe_pkg::MAXSP],
  input  logic [cpe_pkg::ROW_W-1:0]     alpha_row,
  input  logic [cpe_pkg::COEF_W-1:0]    rate,
  input  logic [cpe_pkg::DT_W-1:0]      dt,
  output logic [cpe_pkg::CNT_W-1:0]     next_cnt,
  output logic                          sat_flag
);
  import cpe_pkg::*;

  localparam int unsigned PROD_W = T_W + M_W;
  localparam int unsigned HALF_W = Q_W / 2;
  localparam int unsigned U_W    = D_W - FRAC;

  logic [COEF_W-1:0] alpha_f [MAXSP];
  logic [CNT_W-1:0]  n_self;
  logic [T_W-1:0]    mul_a;
  logic [M_W-1:0]    mul_b;
  logic [PROD_W-1:0] prod;

  logic [ACC_W-1:0]  acc_r;
  logic [T_W-1:0]    t_r;
  logic [Q_W-1:0]    q_r;
  logic              neg_r;
  logic [M_W-1:0]    m_r;
  logic [PROD_W-1:0] prod_r;
  logic [D_W-1:0]    d_r;

  logic [D_W-1:0]    base_w;
  logic [D_W-1:0]    half_w;
  logic [D_W-1:0]    pos_sum;
  logic [D_W-1:0]    neg_diff;
  logic [U_W-1:0]    pos_u;

  assign n_self = counts[LANE];

  // Unpack the coefficient row of this species.
  always_comb begin
    for (int k = 0; k < MAXSP; k++) begin
      alpha_f[k] = alpha_row[k*COEF_W +: COEF_W];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctl.kind)
      PH_MAC: begin
        mul_a = T_W'(alpha_f[ctl.mac_idx]);
        mul_b = M_W'(counts[ctl.mac_idx]);
      end
      PH_RATE: begin
        mul_a = T_W'(rate);
        mul_b = M_W'(n_self);
      end
      PH_DT: begin
        mul_a = t_r;
        mul_b = M_W'(dt);
      end
      PH_LO: begin
        mul_a = T_W'(q_r[HALF_W-1:0]);
        mul_b = m_r;
      end
      PH_HI: begin
        mul_a = T_W'(q_r[Q_W-1:HALF_W]);
        mul_b = m_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Phase registers of the step.
  always_ff @(posedge clk) begin
    case (ctl.kind)
      PH_MAC: begin
        acc_r <= (ctl.mac_first ? '0 : acc_r) + ACC_W'(prod);
      end
      PH_RATE: begin
        t_r <= T_W'(prod);
      end
      PH_DT: begin
        q_r   <= Q_W'(prod);
        neg_r <= (acc_r > ONE_ALPHA);
        m_r   <= (acc_r > ONE_ALPHA) ? (acc_r - ONE_ALPHA) : (ONE_ALPHA - acc_r);
      end
      PH_LO: begin
        d_r <= D_W'(prod);
      end
      PH_HI: begin
        prod_r <= prod;
      end
      PH_ADD: begin
        d_r <= d_r + (D_W'(prod_r) << HALF_W);
      end
      default: begin
      end
    endcase
  end

  // Rounding, clamping at zero and saturation of the new count.
  assign base_w   = D_W'(n_self) << FRAC;
  assign half_w   = D_W'(1) << (FRAC - 1);
  assign pos_sum  = base_w + d_r + half_w;
  assign neg_diff = base_w - d_r + half_w;
  assign pos_u    = pos_sum[D_W-1:FRAC];

  always_comb begin
    sat_flag = 1'b0;
    if (!neg_r) begin
      if (|pos_u[U_W-1:CNT_W]) begin
        next_cnt = '1;
        sat_flag = 1'b1;
      end else begin
        next_cnt = pos_u[CNT_W-1:0];
      end
    end else if (d_r >= base_w) begin
      next_cnt = '0;
    end else begin
      next_cnt = neg_diff[FRAC +: CNT_W];
    end
  end

endmodule

`default_nettype wire

// ===== design/cpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpe_ctrl
// Sequencer of the block: takes an item, runs the phases of every Euler step
// on all lanes at once, and hands the finished counts to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_ctrl #(
  parameter int unsigned SPECIES = cpe_pkg::SPECIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [cpe_pkg::STEP_W-1:0] step_count,
  input  logic                       out_free,
  output logic                       in_ready,
  output cpe_pkg::cpe_ctl_t          ctl
);
  import cpe_pkg::*;

  localparam int unsigned PH_W = $clog2(MAXSP + 7);
  localparam logic [PH_W-1:0] RATE_IDX = PH_W'(SPECIES);
  localparam logic [PH_W-1:0] DT_IDX   = PH_W'(SPECIES + 1);
  localparam logic [PH_W-1:0] LO_IDX   = PH_W'(SPECIES + 2);
  localparam logic [PH_W-1:0] HI_IDX   = PH_W'(SPECIES + 3);
  localparam logic [PH_W-1:0] ADD_IDX  = PH_W'(SPECIES + 4);
  localparam logic [PH_W-1:0] FIN_IDX  = PH_W'(SPECIES + 5);

  cpe_state_t        state_r, state_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      steps_r <= steps_nxt;
    end
  end

  // Next state, phase and remaining step count.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    steps_nxt = steps_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          phase_nxt = '0;
          steps_nxt = step_count;
          state_nxt = (step_count == '0) ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (phase_r == FIN_IDX) begin
          phase_nxt = '0;
          steps_nxt = steps_r - STEP_W'(1);
          if (steps_r == STEP_W'(1)) begin
            state_nxt = ST_HOLD;
          end
        end else begin
          phase_nxt = phase_r + PH_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Handshake and lane controls.
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    ctl.load      = (state_r == ST_IDLE) && in_valid;
    ctl.fin       = (state_r == ST_RUN) && (phase_r == FIN_IDX);
    ctl.out_load  = (state_r == ST_HOLD) && out_free;
    ctl.mac_idx   = phase_r[IDX_W-1:0];
    ctl.mac_first = (phase_r == '0);
    ctl.kind      = PH_NONE;
    if (state_r == ST_RUN) begin
      if (phase_r < RATE_IDX) begin
        ctl.kind = PH_MAC;
      end else begin
        case (phase_r)
          RATE_IDX: ctl.kind = PH_RATE;
          DT_IDX:   ctl.kind = PH_DT;
          LO_IDX:   ctl.kind = PH_LO;
          HI_IDX:   ctl.kind = PH_HI;
          ADD_IDX:  ctl.kind = PH_ADD;
          FIN_IDX:  ctl.kind = PH_FIN;
          default:  ctl.kind = PH_NONE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
